FILE: rtl/qslerp_pkg.sv
// Shared types, constants and constant functions of the quaternion slerp core.
package qslerp_pkg;

    localparam int FRAC_BITS  = 14;
    localparam int TRIG_STEPS = 16;
    localparam int ISQ_STEPS  = FRAC_BITS + 1;
    localparam int DIV_STEPS  = FRAC_BITS + 1;
    localparam int QW         = 16;
    localparam int TW         = QW + 1;
    localparam int DOT_W      = 2 * QW + 2;
    localparam int CW         = 20;
    localparam int SQ_W       = 2 * FRAC_BITS + 1;
    localparam int ISQ_W      = 2 * ISQ_STEPS;
    localparam int NUM_W      = CW - 1 + FRAC_BITS;

    localparam logic [FRAC_BITS:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

    // back pipeline stage positions
    localparam int ST_SQ    = ISQ_STEPS;
    localparam int ST_ATAN  = ST_SQ + TRIG_STEPS;
    localparam int ST_SCALE = ST_ATAN + 1;
    localparam int ST_SIN   = ST_SCALE + TRIG_STEPS;
    localparam int ST_DP    = ST_SIN + 1;
    localparam int ST_DIV   = ST_DP + DIV_STEPS;
    localparam int ST_W     = ST_DIV + 1;
    localparam int ST_P     = ST_W + 1;
    localparam int ST_OUT   = ST_P + 1;

    localparam logic [31:0] ATAN_Q32 [11] = '{
        32'hC90FDAA2, 32'h76B19C16, 32'h3EB6EBF2, 32'h1FD5BA9B,
        32'h0FFAADDC, 32'h07FF556F, 32'h03FFEAAB, 32'h01FFFD55,
        32'h00FFFFAB, 32'h007FFFF5, 32'h003FFFFF
    };

    localparam logic [33:0] GAIN_Q32 = 34'd2608131496;

    function automatic logic signed [CW-1:0] atan_fb(input int i);
        logic [33:0] v;
        begin
            if (i < 11) begin
                v = {2'b00, ATAN_Q32[i]};
            end else begin
                v = 34'(1) << (32 - i);
            end
            return $signed(CW'((v + (34'(1) << (31 - FRAC_BITS))) >> (32 - FRAC_BITS)));
        end
    endfunction

    localparam logic signed [CW-1:0] GAIN_X0 =
        $signed(CW'((GAIN_Q32 + (34'(1) << (31 - FRAC_BITS))) >> (32 - FRAC_BITS)));

    typedef struct packed {
        logic [3:0][QW-1:0]     a;
        logic [3:0][TW-1:0]     t;
        logic [FRAC_BITS:0]     s;
        logic                   lin;
        logic [FRAC_BITS-1:0]   cos;
    } t_mid;

    typedef struct packed {
        logic [3:0][QW-1:0] r;
    } t_res;

endpackage

FILE: rtl/quat_spherical_interpolation_core.sv
// Quaternion slerp core: front end, transaction queue, back-end pipeline, result queue.
// Throughput: one transaction per cycle unless stalled, set by the fully pipelined CORDIC, root and divider.
// Results leave through a two-entry queue; a stalled consumer backs up the back end,
// then the four-entry middle queue, then the front end raises full.
// Synchronous active-low reset empties all queues and pipelines; near_threshold resets to 1.
module quat_spherical_interpolation_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    output logic        o_full,
    input  logic [15:0] i_a_x,
    input  logic [15:0] i_a_y,
    input  logic [15:0] i_a_z,
    input  logic [15:0] i_a_w,
    input  logic [15:0] i_b_x,
    input  logic [15:0] i_b_y,
    input  logic [15:0] i_b_z,
    input  logic [15:0] i_b_w,
    input  logic [14:0] i_frac,
    output logic        o_empty,
    input  logic        i_pop,
    output logic [15:0] o_r_x,
    output logic [15:0] o_r_y,
    output logic [15:0] o_r_z,
    output logic [15:0] o_r_w,
    input  logic        i_cfg_we,
    input  logic [14:0] i_cfg_wdata
);
    import qslerp_pkg::*;

    logic [14:0] r_thr;
    logic mid_push, mid_full, mid_pop, mid_empty;
    t_mid front_mid, back_mid;
    logic out_push, out_full;
    t_res back_res, out_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= 15'd1;
        end else if (i_cfg_we) begin
            r_thr <= i_cfg_wdata;
        end
    end

    qslerp_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (i_push),
        .o_full     (o_full),
        .i_a        ({i_a_w, i_a_z, i_a_y, i_a_x}),
        .i_b        ({i_b_w, i_b_z, i_b_y, i_b_x}),
        .i_frac     (i_frac),
        .i_thr      (r_thr),
        .o_mid_push (mid_push),
        .o_mid      (front_mid),
        .i_mid_full (mid_full)
    );

    qslerp_fifo #(.W($bits(t_mid)), .DEPTH(4)) u_mid_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (mid_push),
        .i_data  (front_mid),
        .o_full  (mid_full),
        .i_pop   (mid_pop),
        .o_data  (back_mid),
        .o_empty (mid_empty)
    );

    qslerp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_mid_empty (mid_empty),
        .o_mid_pop   (mid_pop),
        .i_mid       (back_mid),
        .i_out_full  (out_full),
        .o_out_push  (out_push),
        .o_res       (back_res)
    );

    qslerp_fifo #(.W($bits(t_res)), .DEPTH(2)) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (out_push),
        .i_data  (back_res),
        .o_full  (out_full),
        .i_pop   (i_pop),
        .o_data  (out_res),
        .o_empty (o_empty)
    );

    assign o_r_x = out_res.r[0];
    assign o_r_y = out_res.r[1];
    assign o_r_z = out_res.r[2];
    assign o_r_w = out_res.r[3];

    a_mid_space: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mid_push |-> !mid_full) else $error("middle queue overrun");
    a_out_space: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_push |-> !out_full) else $error("result queue overrun");

endmodule

FILE: rtl/qslerp_fifo.sv
// Small register queue with push/full and pop/empty sides.
module qslerp_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 4
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    input  logic         i_pop,
    output logic [W-1:0] o_data,
    output logic         o_empty
);
    localparam int AW = $clog2(DEPTH);

    logic [W-1:0] r_mem [DEPTH];
    logic [AW-1:0] r_wr, r_rd;
    logic [AW:0] r_cnt;
    logic wr, rd;

    assign o_full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign wr      = i_push && !o_full;
    assign rd      = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr) r_wr <= r_wr + AW'(1);
            if (rd) r_rd <= r_rd + AW'(1);
            if (wr && !rd) r_cnt <= r_cnt + (AW+1)'(1);
            else if (rd && !wr) r_cnt <= r_cnt - (AW+1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) r_mem[r_wr] <= i_data;
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (AW+1)'(DEPTH)) else $error("queue count overflow");
    a_cnt_inc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr && !rd |=> r_cnt == $past(r_cnt) + (AW+1)'(1)) else $error("queue count slip");
    a_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr && o_empty |=> o_data == $past(i_data)) else $error("queue head mismatch");

endmodule

FILE: rtl/qslerp_front.sv
// Front end: dot product, shortest-path negation, cosine and weight-mode classification.
module qslerp_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_push,
    output logic                           o_full,
    input  logic [3:0][qslerp_pkg::QW-1:0] i_a,
    input  logic [3:0][qslerp_pkg::QW-1:0] i_b,
    input  logic [14:0]                    i_frac,
    input  logic [14:0]                    i_thr,
    output logic                           o_mid_push,
    output qslerp_pkg::t_mid               o_mid,
    input  logic                           i_mid_full
);
    import qslerp_pkg::*;

    localparam int CD_W = DOT_W - FRAC_BITS + 1;

    logic en;
    logic r_v1, r_v2, r_v3;
    logic [3:0][QW-1:0] r_a1, r_b1, r_a2, r_b2;
    logic [FRAC_BITS:0] r_s1, r_s2;
    logic signed [2*QW-1:0] r_p1 [4];
    logic signed [DOT_W-1:0] r_dot2, n_dot;
    t_mid r_m3, n_m3;
    logic neg;
    logic [DOT_W-1:0] absd;
    logic [DOT_W-FRAC_BITS-1:0] cosv;
    logic signed [CD_W-1:0] diff;
    logic signed [TW-1:0] bx;

    assign en         = !i_mid_full;
    assign o_full     = !en || !i_rst_n;
    assign o_mid_push = r_v3 && en;
    assign o_mid      = r_m3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_push;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_comb begin
        n_dot = '0;
        for (int k = 0; k < 4; k++) begin
            n_dot = n_dot + DOT_W'(r_p1[k]);
        end
    end

    always_comb begin
        neg  = r_dot2[DOT_W-1];
        absd = neg ? DOT_W'(-r_dot2) : DOT_W'(r_dot2);
        cosv = absd[DOT_W-1:FRAC_BITS];
        diff = $signed(CD_W'(ONE)) - $signed(CD_W'(cosv));
        n_m3.a   = r_a2;
        n_m3.s   = r_s2;
        n_m3.lin = (diff <= $signed(CD_W'(i_thr)));
        n_m3.cos = cosv[FRAC_BITS-1:0];
        for (int k = 0; k < 4; k++) begin
            bx = TW'($signed(r_b2[k]));
            n_m3.t[k] = neg ? -bx : bx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 4; k++) begin
                r_p1[k] <= $signed(i_a[k]) * $signed(i_b[k]);
            end
            r_a1   <= i_a;
            r_b1   <= i_b;
            r_s1   <= (i_frac > ONE) ? ONE : i_frac;
            r_dot2 <= n_dot;
            r_a2   <= r_a1;
            r_b2   <= r_b1;
            r_s2   <= r_s1;
            r_m3   <= n_m3;
        end
    end

endmodule

FILE: rtl/qslerp_isqrt.sv
// Pipelined integer square root, two radicand bits per stage.
module qslerp_isqrt (
    input  logic                           i_clk,
    input  logic                           i_en,
    input  logic [qslerp_pkg::SQ_W-1:0]    i_v,
    output logic [qslerp_pkg::FRAC_BITS:0] o_root
);
    import qslerp_pkg::*;

    logic [ISQ_W-1:0] r_val [ISQ_STEPS-1];
    logic [ISQ_W-1:0] r_root [ISQ_STEPS];
    logic [ISQ_W-1:0] p_v [ISQ_STEPS];
    logic [ISQ_W-1:0] p_r [ISQ_STEPS];
    logic [ISQ_W-1:0] trial [ISQ_STEPS];
    logic [ISQ_W-1:0] n_root [ISQ_STEPS];
    logic [ISQ_STEPS-1:0] hit;

    always_comb begin
        p_v[0] = ISQ_W'(i_v);
        p_r[0] = '0;
        for (int k = 1; k < ISQ_STEPS; k++) begin
            p_v[k] = r_val[k-1];
            p_r[k] = r_root[k-1];
        end
        for (int k = 0; k < ISQ_STEPS; k++) begin
            trial[k]  = p_r[k] + (ISQ_W'(1) << (2 * (ISQ_STEPS - 1 - k)));
            hit[k]    = (p_v[k] >= trial[k]);
            n_root[k] = hit[k] ? (p_r[k] >> 1) + (ISQ_W'(1) << (2 * (ISQ_STEPS - 1 - k)))
                               : (p_r[k] >> 1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < ISQ_STEPS; k++) begin
                r_root[k] <= n_root[k];
            end
            for (int k = 0; k < ISQ_STEPS - 1; k++) begin
                r_val[k] <= hit[k] ? p_v[k] - trial[k] : p_v[k];
            end
        end
    end

    assign o_root = r_root[ISQ_STEPS-1][FRAC_BITS:0];

endmodule

FILE: rtl/qslerp_cordic.sv
// Pipelined CORDIC, one micro-rotation per stage, vectoring or rotation mode.
module qslerp_cordic #(
    parameter bit VECTOR = 1'b0
) (
    input  logic                               i_clk,
    input  logic                               i_en,
    input  logic signed [qslerp_pkg::CW-1:0]   i_x,
    input  logic signed [qslerp_pkg::CW-1:0]   i_y,
    input  logic signed [qslerp_pkg::CW-1:0]   i_z,
    output logic signed [qslerp_pkg::CW-1:0]   o_x,
    output logic signed [qslerp_pkg::CW-1:0]   o_y,
    output logic signed [qslerp_pkg::CW-1:0]   o_z
);
    import qslerp_pkg::*;

    logic signed [CW-1:0] r_x [TRIG_STEPS];
    logic signed [CW-1:0] r_y [TRIG_STEPS];
    logic signed [CW-1:0] r_z [TRIG_STEPS];
    logic signed [CW-1:0] p_x [TRIG_STEPS];
    logic signed [CW-1:0] p_y [TRIG_STEPS];
    logic signed [CW-1:0] p_z [TRIG_STEPS];
    logic signed [CW-1:0] n_x [TRIG_STEPS];
    logic signed [CW-1:0] n_y [TRIG_STEPS];
    logic signed [CW-1:0] n_z [TRIG_STEPS];
    logic up;

    always_comb begin
        p_x[0] = i_x;
        p_y[0] = i_y;
        p_z[0] = i_z;
        for (int k = 1; k < TRIG_STEPS; k++) begin
            p_x[k] = r_x[k-1];
            p_y[k] = r_y[k-1];
            p_z[k] = r_z[k-1];
        end
        up = 1'b0;
        for (int k = 0; k < TRIG_STEPS; k++) begin
            up = VECTOR ? p_y[k][CW-1] : !p_z[k][CW-1];
            if (up) begin
                n_x[k] = p_x[k] - (p_y[k] >>> k);
                n_y[k] = p_y[k] + (p_x[k] >>> k);
                n_z[k] = p_z[k] - atan_fb(k);
            end else begin
                n_x[k] = p_x[k] + (p_y[k] >>> k);
                n_y[k] = p_y[k] - (p_x[k] >>> k);
                n_z[k] = p_z[k] + atan_fb(k);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < TRIG_STEPS; k++) begin
                r_x[k] <= n_x[k];
                r_y[k] <= n_y[k];
                r_z[k] <= n_z[k];
            end
        end
    end

    assign o_x = r_x[TRIG_STEPS-1];
    assign o_y = r_y[TRIG_STEPS-1];
    assign o_z = r_z[TRIG_STEPS-1];

endmodule

FILE: rtl/qslerp_div.sv
// Pipelined restoring divider, one quotient bit per stage, with saturation flag carried.
module qslerp_div (
    input  logic                           i_clk,
    input  logic                           i_en,
    input  logic [qslerp_pkg::NUM_W-1:0]   i_num,
    input  logic [qslerp_pkg::FRAC_BITS:0] i_den,
    input  logic                           i_sat,
    output logic [qslerp_pkg::FRAC_BITS:0] o_q,
    output logic                           o_sat
);
    import qslerp_pkg::*;

    logic [NUM_W-1:0] r_rem [DIV_STEPS-1];
    logic [FRAC_BITS:0] r_den [DIV_STEPS-1];
    logic [FRAC_BITS:0] r_q [DIV_STEPS];
    logic r_sat [DIV_STEPS];
    logic [NUM_W-1:0] p_rem [DIV_STEPS];
    logic [FRAC_BITS:0] p_den [DIV_STEPS];
    logic [FRAC_BITS:0] p_q [DIV_STEPS];
    logic p_sat [DIV_STEPS];
    logic [NUM_W-1:0] dsh [DIV_STEPS];
    logic [DIV_STEPS-1:0] hit;

    always_comb begin
        p_rem[0] = i_num;
        p_den[0] = i_den;
        p_q[0]   = '0;
        p_sat[0] = i_sat;
        for (int k = 1; k < DIV_STEPS; k++) begin
            p_rem[k] = r_rem[k-1];
            p_den[k] = r_den[k-1];
            p_q[k]   = r_q[k-1];
            p_sat[k] = r_sat[k-1];
        end
        for (int k = 0; k < DIV_STEPS; k++) begin
            dsh[k] = NUM_W'(p_den[k]) << (DIV_STEPS - 1 - k);
            hit[k] = (p_rem[k] >= dsh[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < DIV_STEPS; k++) begin
                r_q[k]   <= p_q[k] | ((FRAC_BITS+1)'(hit[k]) << (DIV_STEPS - 1 - k));
                r_sat[k] <= p_sat[k];
            end
            for (int k = 0; k < DIV_STEPS - 1; k++) begin
                r_rem[k] <= hit[k] ? p_rem[k] - dsh[k] : p_rem[k];
                r_den[k] <= p_den[k];
            end
        end
    end

    assign o_q   = r_q[DIV_STEPS-1];
    assign o_sat = r_sat[DIV_STEPS-1];

endmodule

FILE: rtl/qslerp_back.sv
// Back end: angle, partial-angle sines, weights and weighted sum, one transaction per cycle unless stalled.
module qslerp_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_mid_empty,
    output logic               o_mid_pop,
    input  qslerp_pkg::t_mid   i_mid,
    input  logic               i_out_full,
    output logic               o_out_push,
    output qslerp_pkg::t_res   o_res
);
    import qslerp_pkg::*;

    localparam int DEN_LEN = ST_SIN - ST_SQ;
    localparam int MW      = CW + FRAC_BITS + 2;
    localparam int PA_W    = 2 * QW;
    localparam int PT_W    = QW + TW;
    localparam int ACC_W   = PT_W + 1;
    localparam logic signed [ACC_W-1:0] HALF    = ACC_W'(1) <<< (FRAC_BITS - 1);
    localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'(32767);
    localparam logic signed [ACC_W-1:0] SAT_MIN = -ACC_W'(32768);

    logic en;
    logic r_v [ST_OUT+1];
    t_mid r_sd [ST_W+1];
    logic [SQ_W-1:0] r_sqarg;
    logic [FRAC_BITS:0] r_den [DEN_LEN];
    logic [FRAC_BITS:0] root;
    logic signed [CW-1:0] theta, sin0, sin1;
    logic signed [CW-1:0] r_th0, r_th1;
    logic signed [MW-1:0] m0, m1;
    logic [CW-2:0] sp0, sp1;
    logic [NUM_W-1:0] r_num0, r_num1;
    logic r_sat0, r_sat1;
    logic [FRAC_BITS:0] r_dd;
    logic [FRAC_BITS:0] q0, q1;
    logic qs0, qs1;
    logic [FRAC_BITS:0] r_w0, r_w1;
    logic signed [PA_W-1:0] r_pa [4];
    logic signed [PT_W-1:0] r_pt [4];
    logic signed [ACC_W-1:0] acc [4];
    logic signed [ACC_W-1:0] sh [4];
    t_res r_res, n_res;

    assign en         = !i_out_full;
    assign o_mid_pop  = en && !i_mid_empty;
    assign o_out_push = r_v[ST_OUT] && en;
    assign o_res      = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= ST_OUT; k++) r_v[k] <= 1'b0;
        end else if (en) begin
            r_v[0] <= !i_mid_empty;
            for (int k = 1; k <= ST_OUT; k++) r_v[k] <= r_v[k-1];
        end
    end

    // sine of the full angle from the cosine
    qslerp_isqrt u_isqrt (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_v    (r_sqarg),
        .o_root (root)
    );

    qslerp_cordic #(.VECTOR(1'b1)) u_atan (
        .i_clk (i_clk),
        .i_en  (en),
        .i_x   ($signed(CW'(r_sd[ST_SQ].cos))),
        .i_y   ($signed(CW'(root))),
        .i_z   ('0),
        .o_x   (),
        .o_y   (),
        .o_z   (theta)
    );

    assign m0 = $signed({1'b0, ONE - r_sd[ST_ATAN].s}) * theta;
    assign m1 = $signed({1'b0, r_sd[ST_ATAN].s}) * theta;

    qslerp_cordic #(.VECTOR(1'b0)) u_sin0 (
        .i_clk (i_clk),
        .i_en  (en),
        .i_x   (GAIN_X0),
        .i_y   ('0),
        .i_z   (r_th0),
        .o_x   (),
        .o_y   (sin0),
        .o_z   ()
    );

    qslerp_cordic #(.VECTOR(1'b0)) u_sin1 (
        .i_clk (i_clk),
        .i_en  (en),
        .i_x   (GAIN_X0),
        .i_y   ('0),
        .i_z   (r_th1),
        .o_x   (),
        .o_y   (sin1),
        .o_z   ()
    );

    assign sp0 = sin0[CW-1] ? '0 : sin0[CW-2:0];
    assign sp1 = sin1[CW-1] ? '0 : sin1[CW-2:0];

    qslerp_div u_div0 (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (r_num0),
        .i_den (r_dd),
        .i_sat (r_sat0),
        .o_q   (q0),
        .o_sat (qs0)
    );

    qslerp_div u_div1 (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (r_num1),
        .i_den (r_dd),
        .i_sat (r_sat1),
        .o_q   (q1),
        .o_sat (qs1)
    );

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            acc[k] = ACC_W'(r_pa[k]) + ACC_W'(r_pt[k]) + HALF;
            sh[k]  = acc[k] >>> FRAC_BITS;
            if (sh[k] > SAT_MAX) n_res.r[k] = 16'h7FFF;
            else if (sh[k] < SAT_MIN) n_res.r[k] = 16'h8000;
            else n_res.r[k] = sh[k][QW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sd[0] <= i_mid;
            for (int k = 1; k <= ST_W; k++) r_sd[k] <= r_sd[k-1];
            r_sqarg <= {1'b1, {2*FRAC_BITS{1'b0}}}
                       - SQ_W'(SQ_W'(i_mid.cos) * SQ_W'(i_mid.cos));
            r_den[0] <= root;
            for (int k = 1; k < DEN_LEN; k++) r_den[k] <= r_den[k-1];
            r_th0 <= CW'(m0 >>> FRAC_BITS);
            r_th1 <= CW'(m1 >>> FRAC_BITS);
            r_num0 <= {sp0, {FRAC_BITS{1'b0}}};
            r_num1 <= {sp1, {FRAC_BITS{1'b0}}};
            r_sat0 <= (sp0 >= (CW-1)'({r_den[DEN_LEN-1], 1'b0}));
            r_sat1 <= (sp1 >= (CW-1)'({r_den[DEN_LEN-1], 1'b0}));
            r_dd   <= r_den[DEN_LEN-1];
            if (r_sd[ST_DIV].lin) begin
                r_w0 <= ONE - r_sd[ST_DIV].s;
                r_w1 <= r_sd[ST_DIV].s;
            end else begin
                r_w0 <= (qs0 || q0 > ONE) ? ONE : q0;
                r_w1 <= (qs1 || q1 > ONE) ? ONE : q1;
            end
            for (int k = 0; k < 4; k++) begin
                r_pa[k] <= $signed({1'b0, r_w0}) * $signed(r_sd[ST_W].a[k]);
                r_pt[k] <= $signed({1'b0, r_w1}) * $signed(r_sd[ST_W].t[k]);
            end
            r_res <= n_res;
        end
    end

endmodule

FILE: dv/tb_quat_spherical_interpolation_core.sv
// Self-checking testbench for the quaternion slerp core: directed and random transactions.
module tb_quat_spherical_interpolation_core;
    import qslerp_pkg::*;

    localparam int LATENCY   = 73;
    localparam int MAX_CYC   = 400000;
    localparam int N_RANDOM  = 1600;
    localparam longint ONE_L = 64'sd1 << FRAC_BITS;

    typedef struct {
        logic signed [15:0] a [4];
        logic signed [15:0] b [4];
        logic [14:0]        frac;
    } t_pair;

    typedef struct {
        logic [15:0] r [4];
    } t_quat;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_push;
    logic        o_full;
    logic [15:0] i_a_x, i_a_y, i_a_z, i_a_w;
    logic [15:0] i_b_x, i_b_y, i_b_z, i_b_w;
    logic [14:0] i_frac;
    logic        o_empty;
    logic        i_pop;
    logic [15:0] o_r_x, o_r_y, o_r_z, o_r_w;
    logic        i_cfg_we;
    logic [14:0] i_cfg_wdata;

    quat_spherical_interpolation_core i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (i_push),
        .o_full     (o_full),
        .i_a_x      (i_a_x),
        .i_a_y      (i_a_y),
        .i_a_z      (i_a_z),
        .i_a_w      (i_a_w),
        .i_b_x      (i_b_x),
        .i_b_y      (i_b_y),
        .i_b_z      (i_b_z),
        .i_b_w      (i_b_w),
        .i_frac     (i_frac),
        .o_empty    (o_empty),
        .i_pop      (i_pop),
        .o_r_x      (o_r_x),
        .o_r_y      (o_r_y),
        .o_r_z      (o_r_z),
        .o_r_w      (o_r_w),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata)
    );

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    t_quat       slerp_queue[$];
    logic [14:0] near_thr;
    int          n_mismatch;
    int          n_checked;
    int          n_sent;
    int          cyc;

    function automatic longint fshift(longint v, int n);
        return v < 0 ? ~((~v) >>> n) : (v >>> n);
    endfunction

    function automatic longint atan_q(int i);
        longint v;
        begin
            case (i)
                0: v = 64'hC90FDAA2;
                1: v = 64'h76B19C16;
                2: v = 64'h3EB6EBF2;
                3: v = 64'h1FD5BA9B;
                4: v = 64'h0FFAADDC;
                5: v = 64'h07FF556F;
                6: v = 64'h03FFEAAB;
                7: v = 64'h01FFFD55;
                8: v = 64'h00FFFFAB;
                9: v = 64'h007FFFF5;
                10: v = 64'h003FFFFF;
                default: v = 64'sd1 << (32 - i);
            endcase
            return (v + (64'sd1 << (31 - FRAC_BITS))) >>> (32 - FRAC_BITS);
        end
    endfunction

    function automatic longint int_sqrt(longint v);
        longint res, bitv;
        begin
            res = 0;
            bitv = 64'sd1 << 62;
            while (bitv > v) bitv = bitv >>> 2;
            while (bitv != 0) begin
                if (v >= res + bitv) begin
                    v = v - (res + bitv);
                    res = (res >>> 1) + bitv;
                end else begin
                    res = res >>> 1;
                end
                bitv = bitv >>> 2;
            end
            return res;
        end
    endfunction

    function automatic longint angle_of(longint y, longint x);
        longint z, xs, ys;
        begin
            z = 0;
            for (int i = 0; i < TRIG_STEPS; i++) begin
                xs = fshift(x, i);
                ys = fshift(y, i);
                if (y >= 0) begin
                    x += ys; y -= xs; z += atan_q(i);
                end else begin
                    x -= ys; y += xs; z -= atan_q(i);
                end
            end
            return z;
        end
    endfunction

    function automatic longint sine_of(longint z);
        longint x, y, xs, ys;
        begin
            x = (64'd2608131496 + (64'sd1 << (31 - FRAC_BITS))) >>> (32 - FRAC_BITS);
            y = 0;
            for (int i = 0; i < TRIG_STEPS; i++) begin
                xs = fshift(x, i);
                ys = fshift(y, i);
                if (z >= 0) begin
                    x -= ys; y += xs; z -= atan_q(i);
                end else begin
                    x += ys; y -= xs; z += atan_q(i);
                end
            end
            return y;
        end
    endfunction

    function automatic longint clamp_weight(longint sn, longint den);
        longint w;
        begin
            w = (sn * ONE_L) / den;
            if (w < 0) w = 0;
            if (w > ONE_L) w = ONE_L;
            return w;
        end
    endfunction

    function automatic t_quat slerp_predict(t_pair p);
        longint a[4], t[4], dot, cosv, s, w0, w1, sn, theta, r;
        t_quat  q;
        begin
            dot = 0;
            for (int i = 0; i < 4; i++) begin
                a[i] = p.a[i];
                t[i] = p.b[i];
                dot += a[i] * t[i];
            end
            s = p.frac;
            if (s > ONE_L) s = ONE_L;
            if (dot < 0) begin
                for (int i = 0; i < 4; i++) t[i] = -t[i];
                dot = -dot;
            end
            cosv = dot >>> FRAC_BITS;
            if (ONE_L - cosv > longint'(near_thr)) begin
                sn = int_sqrt(ONE_L * ONE_L - cosv * cosv);
                theta = angle_of(sn, cosv);
                if (sn < 1) sn = 1;
                w0 = clamp_weight(sine_of(((ONE_L - s) * theta) >>> FRAC_BITS), sn);
                w1 = clamp_weight(sine_of((s * theta) >>> FRAC_BITS), sn);
            end else begin
                w0 = ONE_L - s;
                w1 = s;
            end
            for (int i = 0; i < 4; i++) begin
                r = fshift(w0 * a[i] + w1 * t[i] + (ONE_L >>> 1), FRAC_BITS);
                if (r > 32767) r = 32767;
                if (r < -32768) r = -32768;
                q.r[i] = r[15:0];
            end
            return q;
        end
    endfunction

    task automatic send_pair(t_pair p);
        int gap;
        begin
            gap = $urandom_range(0, 7);
            if ($urandom_range(0, 3) == 0) gap = 0;
            if (gap > 0) begin
                i_push <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            i_a_x <= p.a[0]; i_a_y <= p.a[1]; i_a_z <= p.a[2]; i_a_w <= p.a[3];
            i_b_x <= p.b[0]; i_b_y <= p.b[1]; i_b_z <= p.b[2]; i_b_w <= p.b[3];
            i_frac <= p.frac;
            i_push <= 1'b1;
            @(posedge i_clk);
            while (o_full) @(posedge i_clk);
            slerp_queue.push_back(slerp_predict(p));
            n_sent++;
            @(negedge i_clk);
        end
    endtask

    task automatic settle();
        begin
            i_push <= 1'b0;
            while (slerp_queue.size() != 0) @(negedge i_clk);
            repeat (4) @(negedge i_clk);
        end
    endtask

    task automatic write_threshold(logic [14:0] v);
        begin
            settle();
            i_cfg_we <= 1'b1;
            i_cfg_wdata <= v;
            @(negedge i_clk);
            i_cfg_we <= 1'b0;
            near_thr = v;
        end
    endtask

    function automatic logic [15:0] rand_comp();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'(ONE_L);
            3: return 16'(-ONE_L);
            default: return 16'($urandom);
        endcase
    endfunction

    // random quaternion pair, unit-ish when unit is set, b optionally near a or its negation
    function automatic t_pair rand_pair(bit unit);
        t_pair p;
        int    k;
        begin
            for (int i = 0; i < 4; i++) begin
                if (unit) begin
                    p.a[i] = 16'($signed($urandom_range(0, 16384)) - 8192);
                end else begin
                    p.a[i] = rand_comp();
                end
            end
            k = $urandom_range(0, 3);
            for (int i = 0; i < 4; i++) begin
                case (unit ? k : 3)
                    0: p.b[i] = p.a[i] + 16'($signed($urandom_range(0, 64)) - 32);
                    1: p.b[i] = -p.a[i] + 16'($signed($urandom_range(0, 64)) - 32);
                    2: p.b[i] = 16'($signed($urandom_range(0, 16384)) - 8192);
                    default: p.b[i] = rand_comp();
                endcase
            end
            case ($urandom_range(0, 5))
                0: p.frac = 15'd0;
                1: p.frac = 15'(ONE_L);
                2: p.frac = 15'($urandom);
                default: p.frac = 15'($urandom_range(0, 16384));
            endcase
            return p;
        end
    endfunction

    task automatic test_directed();
        t_pair p;
        logic signed [15:0] ext [4];
        begin
            ext = '{16'sh8000, 16'sh7FFF, 16'sh0000, 16'shFFFF};
            for (int i = 0; i < 4; i++) begin
                p.a = '{ext[i], ext[i], ext[i], ext[i]};
                p.b = '{ext[3 - i], ext[i], ext[3 - i], ext[i]};
                p.frac = (i == 0) ? 15'h7FFF : 15'(i * 5000);
                send_pair(p);
            end
            // zero inputs
            p.a = '{0, 0, 0, 0}; p.b = '{0, 0, 0, 0}; p.frac = 15'd8192;
            send_pair(p);
            // identical, opposite, orthogonal unit quaternions
            p.a = '{0, 0, 0, 16384}; p.b = '{0, 0, 0, 16384}; p.frac = 15'd4096;
            send_pair(p);
            p.b = '{0, 0, 0, -16384};
            send_pair(p);
            p.b = '{16384, 0, 0, 0}; p.frac = 15'd0;
            send_pair(p);
            p.frac = 15'(ONE_L);
            send_pair(p);
            p.frac = 15'd20000;
            send_pair(p);
            // cosine above one, then a mid-range cosine
            p.a = '{16384, 16384, 0, 0}; p.b = '{16384, 16384, 0, 0}; p.frac = 15'd9000;
            send_pair(p);
            p.a = '{11585, 0, 0, 11585}; p.b = '{0, 11585, 0, 11585};
            send_pair(p);
        end
    endtask

    task automatic test_random(int n);
        begin
            for (int i = 0; i < n; i++) send_pair(rand_pair($urandom_range(0, 3) != 0));
        end
    endtask

    // result checker with random consumer stalls
    initial begin
        t_quat exp_q;
        logic [15:0] got [4];
        int stall;
        i_pop = 1'b0;
        n_mismatch = 0;
        n_checked = 0;
        @(posedge i_rst_n);
        forever begin
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
            @(negedge i_clk);
            if (stall > 0) begin
                i_pop <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_pop <= 1'b1;
            @(posedge i_clk);
            while (o_empty) @(posedge i_clk);
            got = '{o_r_x, o_r_y, o_r_z, o_r_w};
            if (slerp_queue.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= 10) $display("ERROR: unexpected transaction %h", got[0]);
            end else begin
                exp_q = slerp_queue.pop_front();
                n_checked++;
                for (int i = 0; i < 4; i++) begin
                    if (got[i] !== exp_q.r[i]) begin
                        n_mismatch++;
                        if (n_mismatch <= 10) begin
                            $display("ERROR: result %0d comp %0d exp %h got %h",
                                     n_checked, i, exp_q.r[i], got[i]);
                        end
                    end
                end
            end
        end
    end

    initial begin
        cyc = 0;
        forever begin
            @(posedge i_clk);
            cyc++;
            if (cyc > MAX_CYC) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n = 1'b0;
        i_push = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        {i_a_x, i_a_y, i_a_z, i_a_w} = '0;
        {i_b_x, i_b_y, i_b_z, i_b_w} = '0;
        i_frac = '0;
        near_thr = 15'd1;
        n_sent = 0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed();
        test_random(400);
        write_threshold(15'd0);
        test_random(300);
        write_threshold(15'd16384);
        test_directed();
        test_random(300);
        write_threshold(15'h7FFF);
        test_random(100);
        write_threshold(15'($urandom_range(1, 4000)));
        test_random(N_RANDOM - 1100);
        settle();
        repeat (LATENCY + 10) @(negedge i_clk);
        $display("Covered %0d transactions over five threshold settings, %0d results checked.",
                 n_sent, n_checked);
        if (n_mismatch == 0 && slerp_queue.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
